// ===== design/lbr_pkg.sv =====
`default_nettype none

package lbr_pkg;

    localparam int NumChannels = 4;

    localparam int LevelWidth = 16;
    localparam int StepWidth  = 10;
    localparam int BoundWidth = 8;
    localparam int DutyWidth  = 8;
    localparam int YWidth     = 16;
    localparam int FiltWidth  = 11;
    localparam int CountWidth = 10;

    localparam int CfgAddrWidth = 1;
    localparam int CfgDataWidth = 10;

    // input item layout
    localparam int TickBit     = 0;
    localparam int AccelOffset = 1;
    localparam int ReadOkBit   = AccelOffset + YWidth;
    localparam int TapBit      = ReadOkBit + 1;
    localparam int StepOffset  = TapBit + 1;
    localparam int BoundOffset = StepOffset + NumChannels * StepWidth;
    localparam int InBits      = BoundOffset + NumChannels * BoundWidth;
    localparam int InWidth     = ((InBits + 7) / 8) * 8;

    // result item layout
    localparam int EnabledBit = NumChannels * DutyWidth;
    localparam int FlipBit    = EnabledBit + 1;
    localparam int OutBits    = FlipBit + 1;
    localparam int OutWidth   = ((OutBits + 7) / 8) * 8;

    localparam logic [LevelWidth-1:0] LevelMax    = 16'hFFFF;
    localparam logic [StepWidth-1:0]  StepReset   = 10'd600;
    localparam logic [BoundWidth-1:0] TopReset    = 8'd225;
    localparam logic [BoundWidth-1:0] BottomReset = 8'd40;

    localparam logic [CountWidth-1:0] PeriodReset    = 10'd10;
    localparam logic [CountWidth-1:0] ThresholdReset = 10'd220;

    localparam logic signed [YWidth-1:0] YHigh = 16'sd511;
    localparam logic signed [YWidth-1:0] YLow  = -16'sd512;

    // x/10 == (x * 205) >> 11 for 0 <= x <= 1028
    localparam logic [FiltWidth-1:0] Div10Mul   = 11'd205;
    localparam int                   Div10Shift = 11;

    typedef enum logic [CfgAddrWidth-1:0] {
        RegSensorPeriod  = 1'b0,
        RegFlipThreshold = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic enabled;
        logic flip;
    } status_t;

endpackage

`default_nettype wire

// ===== design/lbr_sensor.sv =====
`default_nettype none

module lbr_sensor (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      upd,
    input  wire logic signed [lbr_pkg::YWidth-1:0]         accel_y,
    input  wire logic                                      read_ok,
    input  wire logic                                      tap,
    input  wire logic        [lbr_pkg::CountWidth-1:0]     sensor_period,
    input  wire logic signed [lbr_pkg::CountWidth-1:0]     flip_threshold,
    output lbr_pkg::status_t                               status_next
);

    logic        [lbr_pkg::CountWidth-1:0]   count_reg, count_next, count_inc;
    logic signed [lbr_pkg::FiltWidth-1:0]    fy_reg, fy_next, fy_eval, y_clamp;
    logic signed [lbr_pkg::FiltWidth:0]      diff;
    logic        [lbr_pkg::FiltWidth-1:0]    mag, quot, adj;
    logic        [2*lbr_pkg::FiltWidth-1:0]  scaled;
    logic signed [lbr_pkg::FiltWidth-1:0]    thr_ext;
    logic                                    eval_due, do_eval, flip_eval;
    lbr_pkg::status_t                        status_reg;

    always_comb
    begin
        if (accel_y > lbr_pkg::YHigh)
            y_clamp = lbr_pkg::YHigh[lbr_pkg::FiltWidth-1:0];
        else if (accel_y < lbr_pkg::YLow)
            y_clamp = lbr_pkg::YLow[lbr_pkg::FiltWidth-1:0];
        else
            y_clamp = accel_y[lbr_pkg::FiltWidth-1:0];
    end

    // trunc((y - fy) / 10), magnitude via reciprocal multiply
    assign diff    = $signed({y_clamp[lbr_pkg::FiltWidth-1], y_clamp})
                   - $signed({fy_reg[lbr_pkg::FiltWidth-1], fy_reg});
    assign mag     = diff[lbr_pkg::FiltWidth] ? lbr_pkg::FiltWidth'(-diff)
                                              : diff[lbr_pkg::FiltWidth-1:0];
    assign scaled  = (2*lbr_pkg::FiltWidth)'(mag) * (2*lbr_pkg::FiltWidth)'(lbr_pkg::Div10Mul);
    assign quot    = scaled[lbr_pkg::Div10Shift +: lbr_pkg::FiltWidth];
    assign adj     = diff[lbr_pkg::FiltWidth] ? (~quot + 11'd1) : quot;
    assign fy_eval = fy_reg + $signed(adj);

    assign thr_ext   = $signed({flip_threshold[lbr_pkg::CountWidth-1], flip_threshold});
    assign flip_eval = fy_eval > thr_ext;

    assign count_inc = count_reg + 10'd1;
    assign eval_due  = upd && (count_inc >= sensor_period);
    assign do_eval   = eval_due && read_ok;

    always_comb
    begin
        if (!upd)
            count_next = count_reg;
        else if (eval_due)
            count_next = '0;
        else
            count_next = count_inc;

        fy_next             = do_eval ? fy_eval : fy_reg;
        status_next.flip    = do_eval ? flip_eval : status_reg.flip;
        status_next.enabled = (do_eval && flip_eval && tap) ? !status_reg.enabled
                                                            : status_reg.enabled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg          <= '0;
            fy_reg             <= '0;
            status_reg.enabled <= 1'b1;
            status_reg.flip    <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            fy_reg     <= fy_next;
            status_reg <= status_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lbr_ramp_lane.sv =====
`default_nettype none

module lbr_ramp_lane (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              go,
    input  wire logic [lbr_pkg::StepWidth-1:0]     step_draw,
    input  wire logic [lbr_pkg::BoundWidth-1:0]    bound_draw,
    output logic      [lbr_pkg::LevelWidth-1:0]    level_next,
    output logic      [lbr_pkg::BoundWidth-1:0]    top_next,
    output logic      [lbr_pkg::BoundWidth-1:0]    bottom_next
);

    logic [lbr_pkg::LevelWidth-1:0] level_reg;
    logic                           rising_reg, rising_next;
    logic [lbr_pkg::StepWidth-1:0]  step_reg, step_next;
    logic [lbr_pkg::BoundWidth-1:0] top_reg, bottom_reg;
    logic [lbr_pkg::LevelWidth:0]   sum;

    assign sum = {1'b0, level_reg} + (lbr_pkg::LevelWidth+1)'(step_reg);

    always_comb
    begin
        level_next  = level_reg;
        rising_next = rising_reg;
        step_next   = step_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        if (go)
        begin
            if (rising_reg)
            begin
                if (sum[lbr_pkg::LevelWidth])
                begin
                    level_next  = lbr_pkg::LevelMax;
                    rising_next = 1'b0;
                    step_next   = step_draw;
                    bottom_next = bound_draw;
                end
                else
                    level_next = sum[lbr_pkg::LevelWidth-1:0];
            end
            else
            begin
                if (level_reg < lbr_pkg::LevelWidth'(step_reg))
                begin
                    level_next  = '0;
                    rising_next = 1'b1;
                    step_next   = step_draw;
                    top_next    = bound_draw;
                end
                else
                    level_next = level_reg - lbr_pkg::LevelWidth'(step_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            rising_reg <= 1'b1;
            step_reg   <= lbr_pkg::StepReset;
            top_reg    <= lbr_pkg::TopReset;
            bottom_reg <= lbr_pkg::BottomReset;
        end
        else
        begin
            level_reg  <= level_next;
            rising_reg <= rising_next;
            step_reg   <= step_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/lbr_duty_map.sv =====
`default_nettype none

// duty = bottom + trunc(level * (top - bottom) / 65535), three stages
module lbr_duty_map (
    input  wire logic                              clk,
    input  wire logic                              load1,
    input  wire logic                              load2,
    input  wire logic                              load3,
    input  wire logic [lbr_pkg::LevelWidth-1:0]    level,
    input  wire logic [lbr_pkg::BoundWidth-1:0]    top,
    input  wire logic [lbr_pkg::BoundWidth-1:0]    bottom,
    output logic      [lbr_pkg::DutyWidth-1:0]     duty
);

    localparam int ProdWidth = lbr_pkg::LevelWidth + lbr_pkg::BoundWidth + 2;
    localparam int MagWidth  = lbr_pkg::LevelWidth + lbr_pkg::BoundWidth;

    logic        [lbr_pkg::LevelWidth-1:0]  level1_reg;
    logic        [lbr_pkg::BoundWidth-1:0]  top1_reg, bottom1_reg, bottom2_reg;
    logic signed [lbr_pkg::BoundWidth:0]    span;
    logic signed [ProdWidth-1:0]            prod, prod2_reg;
    logic        [MagWidth-1:0]             mag;
    logic        [lbr_pkg::BoundWidth-1:0]  q0, quot, offs;
    logic        [lbr_pkg::LevelWidth:0]    rem;
    logic        [lbr_pkg::DutyWidth-1:0]   duty_reg, duty_next;
    logic                                   neg;

    assign span = $signed({1'b0, top1_reg}) - $signed({1'b0, bottom1_reg});
    assign prod = $signed({1'b0, level1_reg}) * span;

    // divide by 65535: q0 = n >> 16, remainder n - q0*65535 < 2*65535
    assign neg  = prod2_reg[ProdWidth-1];
    assign mag  = neg ? MagWidth'(-prod2_reg) : prod2_reg[MagWidth-1:0];
    assign q0   = mag[MagWidth-1:lbr_pkg::LevelWidth];
    assign rem  = (lbr_pkg::LevelWidth+1)'(mag[lbr_pkg::LevelWidth-1:0])
                + (lbr_pkg::LevelWidth+1)'(q0);
    assign quot = q0 + lbr_pkg::BoundWidth'(rem >= {1'b0, lbr_pkg::LevelMax});
    assign offs = neg ? (~quot + 8'd1) : quot;
    assign duty_next = bottom2_reg + offs;

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            level1_reg  <= level;
            top1_reg    <= top;
            bottom1_reg <= bottom;
        end
        if (load2)
        begin
            prod2_reg   <= prod;
            bottom2_reg <= bottom1_reg;
        end
        if (load3)
            duty_reg <= duty_next;
    end

    assign duty = duty_reg;

endmodule

`default_nettype wire

// ===== design/led_breathing_ramp_controller.sv =====
// LED breathing ramp controller.
// Input stream (s_*): one item per timer period or idle cycle; tick=0 items only
// report the current state. Each item carries the accelerometer y reading, the
// read status, the tap flag and one random step and bound draw per channel.
// Every item yields exactly one result item on the output stream (m_*): one
// PWM duty per channel plus the LED mode and the turnover flag.
// Configuration: cfg_we writes cfg_data into register cfg_addr (0: sensor
// period, 1: turnover threshold) at the clock edge; write only while idle.
// Throughput: one item per cycle while the output is not stalled. All state (tick
// counter, filter, mode, ramp lanes) updates in the accept cycle; the duty mapping
// follows in a three register pipeline (snapshot, multiply, divide by 65535 into
// the output register), so a result is valid once its item has passed all three.
// When m_tready is low the pipeline holds; s_tready drops only once all three
// stages are full, so up to three results can be in flight.
// Reset (rst_n low, asynchronous): levels 0 and rising, step 600, top 225,
// bottom 40, filter 0, LEDs on, no turnover, sensor period 10, threshold 220;
// the pipeline is emptied.
`default_nettype none

module led_breathing_ramp_controller (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // tick, accel_y[15:0], read_ok, tap, step_draw_0..3[9:0], bound_draw_0..3[7:0]
    input  wire logic [lbr_pkg::InWidth-1:0]           s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // duty_0..3[7:0], leds_enabled, turned_over
    output logic      [lbr_pkg::OutWidth-1:0]          m_tdata,
    input  wire logic                                  cfg_we,
    input  wire logic [lbr_pkg::CfgAddrWidth-1:0]      cfg_addr,
    input  wire logic [lbr_pkg::CfgDataWidth-1:0]      cfg_data
);

    logic [lbr_pkg::CountWidth-1:0] period_reg, period_next;
    logic [lbr_pkg::CountWidth-1:0] threshold_reg, threshold_next;

    logic             accept, upd, go;
    logic             load1, load2, load3;
    logic             v1_reg, v2_reg, v3_reg;
    lbr_pkg::status_t status_next, st1_reg, st2_reg, st3_reg;

    logic [lbr_pkg::DutyWidth-1:0] duty [lbr_pkg::NumChannels];

    always_comb
    begin
        period_next    = period_reg;
        threshold_next = threshold_reg;
        if (cfg_we)
        begin
            unique case (lbr_pkg::reg_index_t'(cfg_addr))
                lbr_pkg::RegSensorPeriod:  period_next    = cfg_data;
                lbr_pkg::RegFlipThreshold: threshold_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign load3    = !v3_reg || m_tready;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign s_tready = load1;
    assign accept   = s_tvalid && load1;
    assign upd      = accept && s_tdata[lbr_pkg::TickBit];
    assign go       = upd && status_next.enabled;

    lbr_sensor u_sensor (
        .clk            (clk),
        .rst_n          (rst_n),
        .upd            (upd),
        .accel_y        ($signed(s_tdata[lbr_pkg::AccelOffset +: lbr_pkg::YWidth])),
        .read_ok        (s_tdata[lbr_pkg::ReadOkBit]),
        .tap            (s_tdata[lbr_pkg::TapBit]),
        .sensor_period  (period_reg),
        .flip_threshold ($signed(threshold_reg)),
        .status_next    (status_next)
    );

    for (genvar g = 0; g < lbr_pkg::NumChannels; g++)
    begin : g_lane
        logic [lbr_pkg::LevelWidth-1:0] level_next;
        logic [lbr_pkg::BoundWidth-1:0] top_next, bottom_next;

        lbr_ramp_lane u_ramp (
            .clk         (clk),
            .rst_n       (rst_n),
            .go          (go),
            .step_draw   (s_tdata[lbr_pkg::StepOffset + g*lbr_pkg::StepWidth
                                  +: lbr_pkg::StepWidth]),
            .bound_draw  (s_tdata[lbr_pkg::BoundOffset + g*lbr_pkg::BoundWidth
                                  +: lbr_pkg::BoundWidth]),
            .level_next  (level_next),
            .top_next    (top_next),
            .bottom_next (bottom_next)
        );

        lbr_duty_map u_map (
            .clk    (clk),
            .load1  (load1),
            .load2  (load2),
            .load3  (load3),
            .level  (level_next),
            .top    (top_next),
            .bottom (bottom_next),
            .duty   (duty[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= lbr_pkg::PeriodReset;
            threshold_reg <= lbr_pkg::ThresholdReset;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end
        else
        begin
            period_reg    <= period_next;
            threshold_reg <= threshold_next;
            if (load1)
                v1_reg <= accept;
            if (load2)
                v2_reg <= v1_reg;
            if (load3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
            st1_reg <= status_next;
        if (load2)
            st2_reg <= st1_reg;
        if (load3)
            st3_reg <= st2_reg;
    end

    // merge lane results into the output item
    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < lbr_pkg::NumChannels; i++)
            m_tdata[i*lbr_pkg::DutyWidth +: lbr_pkg::DutyWidth] = duty[i];
        m_tdata[lbr_pkg::EnabledBit] = st3_reg.enabled;
        m_tdata[lbr_pkg::FlipBit]    = st3_reg.flip;
    end

    assign m_tvalid = v3_reg;

endmodule

`default_nettype wire
